// ===== rtl/core/rpn_stack_machine_exec_top_defines.svh =====
// assertion macros for the stack machine checker
`ifndef RPN_STACK_MACHINE_EXEC_TOP_DEFINES_SVH
`define RPN_STACK_MACHINE_EXEC_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define RSM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the following cycle
`define RSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_pkg
// shared types, opcodes and sizes of the stack machine execution unit
// ----------------------------------------------------------------------------
package rsm_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int PROG_DEPTH  = 1024;
   localparam int NUM_REGS    = 8;
   localparam int DATA_W      = 32;
   localparam int PC_W        = $clog2(PROG_DEPTH);
   localparam int LEN_W       = 11;
   localparam int SP_W        = $clog2(STACK_DEPTH);
   localparam int CNT_W       = SP_W + 1;
   localparam int REG_W       = $clog2(NUM_REGS);
   localparam int KIND_W      = 5;
   localparam int ERR_W       = 3;
   localparam int DIV_CNT_W   = $clog2(DATA_W + 1);

   localparam logic [KIND_W-1:0] OP_CONST = 5'd0;
   localparam logic [KIND_W-1:0] OP_PUSH  = 5'd1;
   localparam logic [KIND_W-1:0] OP_POP   = 5'd2;
   localparam logic [KIND_W-1:0] OP_PRINT = 5'd3;
   localparam logic [KIND_W-1:0] OP_ADD   = 5'd4;
   localparam logic [KIND_W-1:0] OP_SUB   = 5'd5;
   localparam logic [KIND_W-1:0] OP_MPY   = 5'd6;
   localparam logic [KIND_W-1:0] OP_DIV   = 5'd7;
   localparam logic [KIND_W-1:0] OP_MOD   = 5'd8;
   localparam logic [KIND_W-1:0] OP_BRN   = 5'd10;
   localparam logic [KIND_W-1:0] OP_BRNZP = 5'd16;
   localparam logic [KIND_W-1:0] OP_JSR   = 5'd17;
   localparam logic [KIND_W-1:0] OP_JMPR  = 5'd18;

   localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 3'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_DIV0  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_LABEL = 3'd4;
   localparam logic [ERR_W-1:0] ERR_RANGE = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch input item, start stack reads
      logic exec;       // evaluate item and commit non-divide work
      logic div_start;  // load divider
      logic div_step;   // one restoring step
      logic div_finish; // commit divide result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_last;
   } status_type;

   // sign class mask: bit2 negative, bit1 zero, bit0 positive
   function automatic logic [2:0] branch_mask(input logic [KIND_W-1:0] kind);
      logic [2:0] m;
      unique case (kind)
         5'd10:   m = 3'd4;
         5'd11:   m = 3'd2;
         5'd12:   m = 3'd1;
         5'd13:   m = 3'd6;
         5'd14:   m = 3'd5;
         5'd15:   m = 3'd3;
         default: m = 3'd7;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/rsm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module rsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

// ===== rtl/core/rsm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_ctrl
// sequencer: handshake and the step order of one instruction
// ----------------------------------------------------------------------------
module rsm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsm_pkg::status_type    status,
   output rsm_pkg::cmd_type       cmd
);

   rsm_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   // result register is free once taken; accept while it drains
   assign req_stall = (state_ff != rsm_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         rsm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = rsm_pkg::ST_READ;
            end
         end
         rsm_pkg::ST_READ: begin
            state_in = rsm_pkg::ST_EXEC;
         end
         rsm_pkg::ST_EXEC: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = rsm_pkg::ST_DIV;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rsm_pkg::ST_IDLE;
            end
         end
         rsm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = rsm_pkg::ST_DONE;
            end
         end
         rsm_pkg::ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.div_finish = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = rsm_pkg::ST_IDLE;
            end
         end
         default: state_in = rsm_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/core/rsm_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_datapath
// registers, data stack, alu, serial divider and result register
// ----------------------------------------------------------------------------
module rsm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rsm_pkg::cmd_type                    cmd,
   output rsm_pkg::status_type                 status,
   input  logic                                csr_write,
   input  logic [rsm_pkg::LEN_W-1:0]           csr_wdata,
   input  logic [rsm_pkg::KIND_W-1:0]          req_kind,
   input  logic [rsm_pkg::REG_W-1:0]           req_reg_index,
   input  logic signed [rsm_pkg::DATA_W-1:0]   req_immediate,
   input  logic [rsm_pkg::PC_W-1:0]            req_target_pc,
   input  logic                                req_target_found,
   output logic [rsm_pkg::PC_W-1:0]            rsp_next_pc,
   output logic                                rsp_print_valid,
   output logic signed [rsm_pkg::DATA_W-1:0]   rsp_print_value,
   output logic [rsm_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                rsp_halted
);

   localparam int DW = rsm_pkg::DATA_W;

   logic [rsm_pkg::LEN_W-1:0]   len_ff;
   logic [DW-1:0]               regs_ff [rsm_pkg::NUM_REGS];
   logic [rsm_pkg::CNT_W-1:0]   cnt_ff;
   logic [rsm_pkg::PC_W-1:0]    pc_ff;
   logic                        halt_ff;
   logic [rsm_pkg::ERR_W-1:0]   lerr_ff;

   logic [rsm_pkg::KIND_W-1:0]  kind_ff;
   logic [rsm_pkg::REG_W-1:0]   ridx_ff;
   logic [DW-1:0]               imm_ff;
   logic [rsm_pkg::PC_W-1:0]    tgt_ff;
   logic                        found_ff;

   logic [rsm_pkg::PC_W-1:0]    npc_ff;
   logic                        pv_ff;
   logic [DW-1:0]               pval_ff;
   logic [rsm_pkg::ERR_W-1:0]   err_ff;
   logic                        halted_ff;

   // divider
   logic [DW-1:0]               quo_ff, rem_ff, dvs_ff;
   logic                        qneg_ff, rneg_ff, is_mod_ff;
   logic [rsm_pkg::DIV_CNT_W-1:0] dcnt_ff;

   // stack memory
   logic                        wr_en;
   logic [rsm_pkg::SP_W-1:0]    wr_addr, rd_addr_a, rd_addr_b;
   logic [DW-1:0]               wr_data, top_a, top_b;

   rsm_ram #(.WIDTH(DW), .DEPTH(rsm_pkg::STACK_DEPTH)) u_stack (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (top_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (top_b)
   );

   // a is the top entry, b the one below
   assign rd_addr_a = rsm_pkg::SP_W'(cnt_ff - 1'b1);
   assign rd_addr_b = rsm_pkg::SP_W'(cnt_ff - 2'd2);

   logic [rsm_pkg::PC_W:0]      eff_len;
   logic [rsm_pkg::PC_W-1:0]    adv_pc;
   logic [DW-1:0]               rv;
   logic                        is_arith, is_br, take, full, do_exec;
   logic [2:0]                  sgn;

   always_comb begin
      eff_len = (len_ff > rsm_pkg::LEN_W'(rsm_pkg::PROG_DEPTH))
         ? (rsm_pkg::PC_W+1)'(rsm_pkg::PROG_DEPTH) : (rsm_pkg::PC_W+1)'(len_ff);
      adv_pc  = (pc_ff == rsm_pkg::PC_W'(rsm_pkg::PROG_DEPTH - 1))
         ? '0 : pc_ff + 1'b1;
      rv      = regs_ff[ridx_ff];
      sgn     = rv[DW-1] ? 3'd4 : ((rv == '0) ? 3'd2 : 3'd1);
      is_arith = (kind_ff >= rsm_pkg::OP_ADD) && (kind_ff <= rsm_pkg::OP_MOD);
      is_br    = (kind_ff >= rsm_pkg::OP_BRN) && (kind_ff <= rsm_pkg::OP_BRNZP);
      take     = !is_br || ((rsm_pkg::branch_mask(kind_ff) & sgn) != 3'd0);
      full     = (cnt_ff >= rsm_pkg::CNT_W'(rsm_pkg::STACK_DEPTH));
   end

   assign status.need_div = !halt_ff && (cnt_ff >= 2) && (top_b != '0)
      && ((kind_ff == rsm_pkg::OP_DIV) || (kind_ff == rsm_pkg::OP_MOD));
   assign status.div_last = (dcnt_ff == rsm_pkg::DIV_CNT_W'(1));

   // evaluation of everything except the divide
   logic [rsm_pkg::ERR_W-1:0]   e;
   logic [rsm_pkg::PC_W-1:0]    npc;
   logic                        pv;
   logic [DW-1:0]               res;
   logic                        w_reg, push_top, arith_wr;
   logic [DW-1:0]               w_reg_val;
   logic [DW-1:0]               prod;

   assign prod = top_a * top_b;

   always_comb begin
      e = rsm_pkg::ERR_NONE;
      npc = adv_pc; pv = 1'b0;
      res = '0; w_reg = 1'b0; w_reg_val = imm_ff;
      push_top = 1'b0; arith_wr = 1'b0;
      priority if (kind_ff == rsm_pkg::OP_CONST) begin
         w_reg = 1'b1;
      end else if (kind_ff == rsm_pkg::OP_PUSH) begin
         if (full) e = rsm_pkg::ERR_FULL; else push_top = 1'b1;
      end else if (kind_ff == rsm_pkg::OP_POP) begin
         if (cnt_ff == '0) e = rsm_pkg::ERR_EMPTY;
         else begin w_reg = 1'b1; w_reg_val = top_a; end
      end else if (kind_ff == rsm_pkg::OP_PRINT) begin
         if (cnt_ff == '0) e = rsm_pkg::ERR_EMPTY; else pv = 1'b1;
      end else if (is_arith) begin
         if (cnt_ff < 2) e = rsm_pkg::ERR_EMPTY;
         else begin
            unique case (kind_ff)
               rsm_pkg::OP_ADD: res = top_a + top_b;
               rsm_pkg::OP_SUB: res = top_a - top_b;
               rsm_pkg::OP_MPY: res = prod;
               default:         res = '0;
            endcase
            // only a zero divisor reaches here for div and mod
            if ((kind_ff == rsm_pkg::OP_DIV) || (kind_ff == rsm_pkg::OP_MOD))
               e = rsm_pkg::ERR_DIV0;
            else arith_wr = 1'b1;
         end
      end else if (is_br || kind_ff == rsm_pkg::OP_JSR) begin
         if (kind_ff == rsm_pkg::OP_JSR && full) e = rsm_pkg::ERR_FULL;
         else if (take) begin
            if (!found_ff) e = rsm_pkg::ERR_LABEL;
            else if ((rsm_pkg::PC_W+1)'(tgt_ff) >= eff_len) e = rsm_pkg::ERR_RANGE;
            else npc = tgt_ff;
         end
      end else if (kind_ff == rsm_pkg::OP_JMPR) begin
         if (rv[DW-1] || rv >= DW'(eff_len)) e = rsm_pkg::ERR_RANGE;
         else npc = rv[rsm_pkg::PC_W-1:0];
      end else begin
      end
   end

   assign do_exec = cmd.exec && !halt_ff && (e == rsm_pkg::ERR_NONE);

   logic [DW-1:0] div_res;
   assign div_res = is_mod_ff ? (rneg_ff ? -rem_ff : rem_ff)
                              : (qneg_ff ? -quo_ff : quo_ff);

   always_comb begin
      wr_en = 1'b0; wr_addr = rsm_pkg::SP_W'(cnt_ff); wr_data = rv;
      if (cmd.div_finish) begin
         wr_en = 1'b1; wr_addr = rd_addr_b; wr_data = div_res;
      end else if (do_exec && push_top) begin
         wr_en = 1'b1;
         wr_data = (kind_ff == rsm_pkg::OP_JSR) ? DW'(adv_pc) : rv;
      end else if (do_exec && arith_wr) begin
         wr_en = 1'b1; wr_addr = rd_addr_b; wr_data = res;
      end else if (do_exec && kind_ff == rsm_pkg::OP_JSR && npc == tgt_ff
                   && take && found_ff) begin
         wr_en = 1'b1; wr_data = DW'(adv_pc);
      end
   end

   logic jsr_push;
   assign jsr_push = do_exec && (kind_ff == rsm_pkg::OP_JSR);

   // restoring divide step on magnitudes
   logic [DW:0] trial;
   assign trial = {rem_ff, quo_ff[DW-1]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= rsm_pkg::LEN_W'(rsm_pkg::PROG_DEPTH);
         cnt_ff  <= '0;
         pc_ff   <= '0;
         halt_ff <= 1'b0;
         lerr_ff <= rsm_pkg::ERR_NONE;
         for (int i = 0; i < rsm_pkg::NUM_REGS; i++) regs_ff[i] <= '0;
      end else begin
         if (csr_write) len_ff <= csr_wdata;
         if (cmd.exec && !halt_ff) begin
            if (e != rsm_pkg::ERR_NONE) begin
               halt_ff <= 1'b1; lerr_ff <= e;
            end else begin
               pc_ff <= npc;
               if (w_reg) regs_ff[ridx_ff] <= w_reg_val;
               if (push_top || jsr_push) cnt_ff <= cnt_ff + 1'b1;
               else if (kind_ff == rsm_pkg::OP_POP || arith_wr)
                  cnt_ff <= cnt_ff - 1'b1;
            end
         end
         if (cmd.div_finish) begin
            pc_ff  <= adv_pc;
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         ridx_ff  <= req_reg_index;
         imm_ff   <= req_immediate;
         tgt_ff   <= req_target_pc;
         found_ff <= req_target_found;
      end
      if (cmd.div_start) begin
         quo_ff    <= top_a[DW-1] ? -top_a : top_a;
         dvs_ff    <= top_b[DW-1] ? -top_b : top_b;
         rem_ff    <= '0;
         qneg_ff   <= top_a[DW-1] ^ top_b[DW-1];
         rneg_ff   <= top_a[DW-1];
         is_mod_ff <= (kind_ff == rsm_pkg::OP_MOD);
         dcnt_ff   <= rsm_pkg::DIV_CNT_W'(DW);
      end else if (cmd.div_step) begin
         if (!trial[DW]) begin
            rem_ff <= trial[DW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DW-2:0], quo_ff[DW-1]};
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 1'b1;
      end
      if (cmd.exec) begin
         if (halt_ff) begin
            npc_ff <= pc_ff; pv_ff <= 1'b0; pval_ff <= '0;
            err_ff <= lerr_ff; halted_ff <= 1'b1;
         end else if (e != rsm_pkg::ERR_NONE) begin
            npc_ff <= pc_ff; pv_ff <= 1'b0; pval_ff <= '0;
            err_ff <= e; halted_ff <= 1'b1;
         end else begin
            npc_ff <= npc; pv_ff <= pv; pval_ff <= pv ? top_a : '0;
            err_ff <= rsm_pkg::ERR_NONE; halted_ff <= 1'b0;
         end
      end
      if (cmd.div_finish) begin
         npc_ff <= adv_pc; pv_ff <= 1'b0; pval_ff <= '0;
         err_ff <= rsm_pkg::ERR_NONE; halted_ff <= 1'b0;
      end
   end

   assign rsp_next_pc     = npc_ff;
   assign rsp_print_valid = pv_ff;
   assign rsp_print_value = pval_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_halted      = halted_ff;

endmodule

// ===== rtl/core/rpn_stack_machine_exec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_machine_exec_top
// executes one decoded stack calculator instruction per item
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  kind, reg_index, immediate, target_pc, ..
// rsp      out  rsp_valid/rsp_stall  next_pc, print_valid, print_value, ..
// csr      in   csr_write            csr_wdata (program_length)
//
// most instructions step through capture, stack read and execute; div and
// mod also run the one-bit-per-cycle restoring divider before committing.
// synchronous reset clears registers, stack count, pc and halt state.
// a new item is taken while the last result still waits; execute holds
// while the result register is full and stalled.
module rpn_stack_machine_exec_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rsm_pkg::KIND_W-1:0]          req_kind,
   input  logic [rsm_pkg::REG_W-1:0]           req_reg_index,
   input  logic signed [rsm_pkg::DATA_W-1:0]   req_immediate,
   input  logic [rsm_pkg::PC_W-1:0]            req_target_pc,
   input  logic                                req_target_found,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rsm_pkg::PC_W-1:0]            rsp_next_pc,
   output logic                                rsp_print_valid,
   output logic signed [rsm_pkg::DATA_W-1:0]   rsp_print_value,
   output logic [rsm_pkg::ERR_W-1:0]           rsp_error_code,
   output logic                                rsp_halted,
   input  logic                                csr_write,
   input  logic [rsm_pkg::LEN_W-1:0]           csr_wdata
);

   rsm_pkg::cmd_type    cmd;
   rsm_pkg::status_type status;

   rsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rsm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_write),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_reg_index    (req_reg_index),
      .req_immediate    (req_immediate),
      .req_target_pc    (req_target_pc),
      .req_target_found (req_target_found),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_print_valid  (rsp_print_valid),
      .rsp_print_value  (rsp_print_value),
      .rsp_error_code   (rsp_error_code),
      .rsp_halted       (rsp_halted)
   );

endmodule

// ===== rtl/core/rsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsm_checker
// port level checks of the stack machine execution unit
// ----------------------------------------------------------------------------
`include "rpn_stack_machine_exec_top_defines.svh"

module rsm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_print_valid,
   input logic [rsm_pkg::ERR_W-1:0]    rsp_error_code,
   input logic                         rsp_halted
);

   `RSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `RSM_ASSERT_IMP(a_err_halts, clock, reset, rsp_valid && (rsp_error_code != rsm_pkg::ERR_NONE), rsp_halted, "error without halt")
   `RSM_ASSERT_IMP(a_halt_noprint, clock, reset, rsp_valid && rsp_halted, !rsp_print_valid, "print while halted")
   `RSM_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "second item taken while busy")

endmodule

bind rpn_stack_machine_exec_top rsm_checker u_rsm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_print_valid (rsp_print_valid),
   .rsp_error_code  (rsp_error_code),
   .rsp_halted      (rsp_halted)
);

// ===== dv/rpn_stack_machine_exec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_machine_exec_checker
// watches the instruction and result channels of the stack machine, keeps
// its own copy of registers, stack, pc and halt state, predicts each result
// and compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module rpn_stack_machine_exec_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [rsm_pkg::KIND_W-1:0]        req_kind,
   input  logic [rsm_pkg::REG_W-1:0]         req_reg_index,
   input  logic signed [rsm_pkg::DATA_W-1:0] req_immediate,
   input  logic [rsm_pkg::PC_W-1:0]          req_target_pc,
   input  logic                              req_target_found,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [rsm_pkg::PC_W-1:0]          rsp_next_pc,
   input  logic                              rsp_print_valid,
   input  logic signed [rsm_pkg::DATA_W-1:0] rsp_print_value,
   input  logic [rsm_pkg::ERR_W-1:0]         rsp_error_code,
   input  logic                              rsp_halted,
   input  logic                              csr_write,
   input  logic [rsm_pkg::LEN_W-1:0]         csr_wdata,
   output int                                fail_count,
   output int                                pending_count
);

   typedef struct {
      logic [rsm_pkg::PC_W-1:0]   npc;
      logic                       pv;
      logic [rsm_pkg::DATA_W-1:0] pval;
      logic [rsm_pkg::ERR_W-1:0]  err;
      logic                       halt;
   } outcome_type;

   outcome_type                outcome_q[$];
   logic [rsm_pkg::DATA_W-1:0] regs [rsm_pkg::NUM_REGS];
   logic [rsm_pkg::DATA_W-1:0] stk [rsm_pkg::STACK_DEPTH];
   int                         depth;
   logic [rsm_pkg::PC_W-1:0]   pc;
   logic                       stopped;
   logic [rsm_pkg::ERR_W-1:0]  last_err;
   logic [rsm_pkg::LEN_W-1:0]  prog_len;

   assign pending_count = outcome_q.size();

   function automatic int span();
      return (prog_len > rsm_pkg::PROG_DEPTH) ? rsm_pkg::PROG_DEPTH : int'(prog_len);
   endfunction

   task automatic execute(input logic [rsm_pkg::KIND_W-1:0] kind,
                          input logic [rsm_pkg::REG_W-1:0] r,
                          input logic [rsm_pkg::DATA_W-1:0] imm,
                          input logic [rsm_pkg::PC_W-1:0] tgt,
                          input logic found);
      outcome_type                o;
      logic [rsm_pkg::DATA_W-1:0] a, b, res, v;
      logic [2:0]                 mask, sgn;
      logic                       take;
      o.npc  = pc + 1'b1;  // 10-bit wrap after the last slot
      o.pv   = 1'b0;
      o.pval = '0;
      o.err  = rsm_pkg::ERR_NONE;
      o.halt = 1'b0;
      if (stopped) begin
         o.npc  = pc;
         o.err  = last_err;
         o.halt = 1'b1;
         outcome_q.push_back(o);
         return;
      end
      if (kind == rsm_pkg::OP_CONST) begin
         regs[r] = imm;
      end else if (kind == rsm_pkg::OP_PUSH) begin
         if (depth >= rsm_pkg::STACK_DEPTH) o.err = rsm_pkg::ERR_FULL;
         else begin
            stk[depth] = regs[r];
            depth++;
         end
      end else if (kind == rsm_pkg::OP_POP) begin
         if (depth == 0) o.err = rsm_pkg::ERR_EMPTY;
         else begin
            depth--;
            regs[r] = stk[depth];
         end
      end else if (kind == rsm_pkg::OP_PRINT) begin
         if (depth == 0) o.err = rsm_pkg::ERR_EMPTY;
         else begin
            o.pv   = 1'b1;
            o.pval = stk[depth-1];
         end
      end else if (kind >= rsm_pkg::OP_ADD && kind <= rsm_pkg::OP_MOD) begin
         if (depth < 2) o.err = rsm_pkg::ERR_EMPTY;
         else begin
            a   = stk[depth-1];
            b   = stk[depth-2];
            res = '0;
            case (kind)
               rsm_pkg::OP_ADD: res = a + b;
               rsm_pkg::OP_SUB: res = a - b;
               rsm_pkg::OP_MPY: res = a * b;
               default: begin
                  if (b == 0) o.err = rsm_pkg::ERR_DIV0;
                  else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                     res = (kind == rsm_pkg::OP_DIV) ? a : '0;
                  else if (kind == rsm_pkg::OP_DIV) res = $signed(a) / $signed(b);
                  else res = $signed(a) % $signed(b);
               end
            endcase
            if (o.err == rsm_pkg::ERR_NONE) begin
               depth--;
               stk[depth-1] = res;
            end
         end
      end else if (kind >= rsm_pkg::OP_BRN && kind <= rsm_pkg::OP_JSR) begin
         take = 1'b1;
         if (kind <= rsm_pkg::OP_BRNZP) begin
            v   = regs[r];
            sgn = v[31] ? 3'd4 : (v == 0 ? 3'd2 : 3'd1);
            case (kind - rsm_pkg::OP_BRN)
               0: mask = 3'd4;
               1: mask = 3'd2;
               2: mask = 3'd1;
               3: mask = 3'd6;
               4: mask = 3'd5;
               5: mask = 3'd3;
               default: mask = 3'd7;
            endcase
            take = (mask & sgn) != 0;
         end else if (depth >= rsm_pkg::STACK_DEPTH) begin
            o.err = rsm_pkg::ERR_FULL;
         end
         if (o.err == rsm_pkg::ERR_NONE && take) begin
            if (!found) o.err = rsm_pkg::ERR_LABEL;
            else if (tgt >= span()) o.err = rsm_pkg::ERR_RANGE;
            else begin
               if (kind == rsm_pkg::OP_JSR) begin
                  stk[depth] = rsm_pkg::DATA_W'(o.npc);
                  depth++;
               end
               o.npc = tgt;
            end
         end
      end else if (kind == rsm_pkg::OP_JMPR) begin
         v = regs[r];
         if (v[31] || v >= span()) o.err = rsm_pkg::ERR_RANGE;
         else o.npc = v[rsm_pkg::PC_W-1:0];
      end
      if (o.err != rsm_pkg::ERR_NONE) begin
         stopped  = 1'b1;
         last_err = o.err;
         o.npc    = pc;
         o.pv     = 1'b0;
         o.pval   = '0;
      end else begin
         pc = o.npc;
      end
      o.halt = stopped;
      outcome_q.push_back(o);
   endtask

   task automatic compare(input outcome_type o);
      if (rsp_next_pc !== o.npc) begin
         $error("next_pc: expected %0d, actual %0d", o.npc, rsp_next_pc);
         fail_count++;
      end
      if (rsp_print_valid !== o.pv) begin
         $error("print_valid: expected %0d, actual %0d", o.pv, rsp_print_valid);
         fail_count++;
      end
      if (rsp_print_value !== o.pval) begin
         $error("print_value: expected %0d, actual %0d", $signed(o.pval), rsp_print_value);
         fail_count++;
      end
      if (rsp_error_code !== o.err) begin
         $error("error_code: expected %0d, actual %0d", o.err, rsp_error_code);
         fail_count++;
      end
      if (rsp_halted !== o.halt) begin
         $error("halted: expected %0d, actual %0d", o.halt, rsp_halted);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         foreach (regs[i]) regs[i] = '0;
         depth    = 0;
         pc       = '0;
         stopped  = 1'b0;
         last_err = rsm_pkg::ERR_NONE;
         prog_len = 11'd1024;
         outcome_q.delete();
      end else begin
         if (csr_write) prog_len = csr_wdata;
         if (req_valid && !req_stall)
            execute(req_kind, req_reg_index, req_immediate, req_target_pc, req_target_found);
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               $error("result item with no expectation waiting, next_pc %0d", rsp_next_pc);
               fail_count++;
            end else begin
               compare(outcome_q.pop_front());
            end
         end
      end
   end

endmodule

// ===== dv/tb_rpn_stack_machine_exec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rpn_stack_machine_exec_top
// drives legal instruction sequences with random content through the stack
// machine under several program lengths and idle patterns, ends with one
// randomly chosen fault and a few items while halted; the checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module tb_rpn_stack_machine_exec_top;

   localparam logic [rsm_pkg::KIND_W-1:0] OP_LABEL = 5'd9;
   localparam int DRAIN_CYCLES = 48;
   localparam int CYCLE_LIMIT  = 600000;

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [rsm_pkg::KIND_W-1:0]        req_kind;
   logic [rsm_pkg::REG_W-1:0]         req_reg_index;
   logic signed [rsm_pkg::DATA_W-1:0] req_immediate;
   logic [rsm_pkg::PC_W-1:0]          req_target_pc;
   logic                              req_target_found;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [rsm_pkg::PC_W-1:0]          rsp_next_pc;
   logic                              rsp_print_valid;
   logic signed [rsm_pkg::DATA_W-1:0] rsp_print_value;
   logic [rsm_pkg::ERR_W-1:0]         rsp_error_code;
   logic                              rsp_halted;
   logic                              csr_write;
   logic [rsm_pkg::LEN_W-1:0]         csr_wdata;

   int fail_count;
   int pending_count;
   int sent;
   int received;
   int cycles;
   int send_idle_pct;
   int stall_pct;
   int depth;     // stack entries the issued program has built
   int prog_span;

   rpn_stack_machine_exec_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_reg_index(req_reg_index), .req_immediate(req_immediate),
      .req_target_pc(req_target_pc), .req_target_found(req_target_found),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_next_pc(rsp_next_pc),
      .rsp_print_valid(rsp_print_valid), .rsp_print_value(rsp_print_value),
      .rsp_error_code(rsp_error_code), .rsp_halted(rsp_halted),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   rpn_stack_machine_exec_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_reg_index(req_reg_index), .req_immediate(req_immediate),
      .req_target_pc(req_target_pc), .req_target_found(req_target_found),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_next_pc(rsp_next_pc),
      .rsp_print_valid(rsp_print_valid), .rsp_print_value(rsp_print_value),
      .rsp_error_code(rsp_error_code), .rsp_halted(rsp_halted),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) received++;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send(input logic [rsm_pkg::KIND_W-1:0] kind,
                       input logic [rsm_pkg::REG_W-1:0] r,
                       input logic [rsm_pkg::DATA_W-1:0] imm,
                       input logic [rsm_pkg::PC_W-1:0] tgt,
                       input logic found);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_reg_index    <= r;
      req_immediate    <= imm;
      req_target_pc    <= tgt;
      req_target_found <= found;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
      case (kind)
         rsm_pkg::OP_PUSH, rsm_pkg::OP_JSR: depth++;
         rsm_pkg::OP_POP, rsm_pkg::OP_ADD, rsm_pkg::OP_SUB, rsm_pkg::OP_MPY,
         rsm_pkg::OP_DIV, rsm_pkg::OP_MOD: depth--;
         default: ;
      endcase
   endtask

   // hold off until the block is idle, then write the program length
   task automatic set_length(input logic [rsm_pkg::LEN_W-1:0] len);
      req_valid <= 1'b0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_write <= 1'b0;
      prog_span = (len > rsm_pkg::PROG_DEPTH) ? rsm_pkg::PROG_DEPTH : int'(len);
   endtask

   function automatic logic [rsm_pkg::PC_W-1:0] legal_target();
      return rsm_pkg::PC_W'($urandom_range(prog_span - 1));
   endfunction

   // a op b with b pushed first; b nonzero so divide cannot fault
   task automatic arith_seq(input logic [rsm_pkg::KIND_W-1:0] op,
                            input logic [rsm_pkg::DATA_W-1:0] a,
                            input logic [rsm_pkg::DATA_W-1:0] b);
      logic [rsm_pkg::REG_W-1:0] ra, rb;
      ra = $urandom;
      rb = ra + 1'b1;
      send(rsm_pkg::OP_CONST, ra, a, $urandom, $urandom);
      send(rsm_pkg::OP_CONST, rb, b, $urandom, $urandom);
      send(rsm_pkg::OP_PUSH, rb, $urandom, $urandom, $urandom);
      send(rsm_pkg::OP_PUSH, ra, $urandom, $urandom, $urandom);
      send(op, $urandom, $urandom, $urandom, $urandom);
      if ($urandom_range(1)) send(rsm_pkg::OP_PRINT, $urandom, $urandom, $urandom, $urandom);
      send(rsm_pkg::OP_POP, $urandom, $urandom, $urandom, $urandom);
   endtask

   // branch whose register sign is set so it falls through, label missing or not
   task automatic untaken_branch();
      logic [rsm_pkg::KIND_W-1:0] kind;
      logic [rsm_pkg::REG_W-1:0]  r;
      logic [rsm_pkg::DATA_W-1:0] v;
      int                         k;
      k = $urandom_range(5);
      case (k)
         0: v = $urandom_range(1, 32'h7FFF_FFFF);    // n only
         1: v = $urandom | 32'h1;                    // z only
         2: v = 32'h8000_0000 | $urandom;            // p only
         3: v = $urandom_range(1, 32'h7FFF_FFFF);    // nz
         4: v = 32'h0;                               // np
         default: v = 32'h8000_0000 | $urandom;      // zp
      endcase
      if (k == 1 && v == 0) v = 32'h5;
      kind = rsm_pkg::OP_BRN + rsm_pkg::KIND_W'(k);
      r    = $urandom;
      send(rsm_pkg::OP_CONST, r, v, $urandom, $urandom);
      send(kind, r, $urandom, $urandom, $urandom);
   endtask

   task automatic random_step();
      logic [rsm_pkg::REG_W-1:0] r;
      int                        pick;
      r    = $urandom;
      pick = $urandom_range(99);
      if (depth > 48 && pick < 40) pick = 30;
      if (pick < 10) begin
         send(rsm_pkg::OP_CONST, r, $urandom, $urandom, $urandom);
      end else if (pick < 25) begin
         if (depth < rsm_pkg::STACK_DEPTH)
            send(rsm_pkg::OP_PUSH, r, $urandom, $urandom, $urandom);
      end else if (pick < 35) begin
         if (depth > 0)
            send($urandom_range(1) ? rsm_pkg::OP_POP : rsm_pkg::OP_PRINT, r, $urandom,
                 $urandom, $urandom);
      end else if (pick < 45) begin
         if (depth >= 2)
            send(rsm_pkg::OP_ADD + rsm_pkg::KIND_W'($urandom_range(2)), r, $urandom,
                 $urandom, $urandom);
      end else if (pick < 60) begin
         if (depth <= rsm_pkg::STACK_DEPTH - 2)
            arith_seq(rsm_pkg::OP_ADD + rsm_pkg::KIND_W'($urandom_range(4)), $urandom,
                      $urandom_range(1) ? $urandom | 32'h1 : $urandom_range(1, 9));
      end else if (pick < 70) begin
         send(rsm_pkg::OP_BRN + rsm_pkg::KIND_W'($urandom_range(6)), r, $urandom,
              legal_target(), 1'b1);
      end else if (pick < 78) begin
         untaken_branch();
      end else if (pick < 85) begin
         send(rsm_pkg::OP_CONST, r, $urandom_range(prog_span - 1), $urandom, $urandom);
         send(rsm_pkg::OP_JMPR, r, $urandom, $urandom, $urandom);
      end else if (pick < 92) begin
         if (depth < rsm_pkg::STACK_DEPTH)
            send(rsm_pkg::OP_JSR, r, $urandom, legal_target(), 1'b1);
      end else begin
         send($urandom_range(1) ? OP_LABEL : rsm_pkg::KIND_W'($urandom_range(19, 31)), r,
              $urandom, $urandom, $urandom);
      end
   endtask

   task automatic directed();
      send(rsm_pkg::OP_CONST, 3'd0, 32'h7FFF_FFFF, '0, 1'b0);
      send(rsm_pkg::OP_CONST, 3'd7, 32'h8000_0000, '1, 1'b1);
      send(rsm_pkg::OP_PUSH, 3'd0, '0, '0, 1'b0);
      send(rsm_pkg::OP_PUSH, 3'd7, '0, '0, 1'b0);
      send(rsm_pkg::OP_PRINT, 3'd0, '0, '0, 1'b0);
      send(rsm_pkg::OP_ADD, 3'd0, '0, '0, 1'b0);
      send(rsm_pkg::OP_POP, 3'd5, '0, '0, 1'b0);
      arith_seq(rsm_pkg::OP_SUB, 32'h0, 32'h1);
      arith_seq(rsm_pkg::OP_MPY, 32'hFFFF_FFFF, 32'h8000_0000);
      arith_seq(rsm_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      arith_seq(rsm_pkg::OP_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
      arith_seq(rsm_pkg::OP_DIV, 32'hFFFF_FFF9, 32'h2);
      arith_seq(rsm_pkg::OP_MOD, 32'h7, 32'hFFFF_FFFE);
      for (int k = 0; k < 7; k++)
         send(rsm_pkg::OP_BRN + rsm_pkg::KIND_W'(k), 3'(k), '0, 10'(k * 100 + 3), 1'b1);
      untaken_branch();
      send(rsm_pkg::OP_JSR, 3'd1, '0, 10'd1023, 1'b1);
      send(rsm_pkg::OP_POP, 3'd1, '0, '0, 1'b0);
      // walk off the end of program memory back to slot 0
      send(rsm_pkg::OP_CONST, 3'd2, 32'd1021, '0, 1'b0);
      send(rsm_pkg::OP_JMPR, 3'd2, '0, '0, 1'b0);
      send(OP_LABEL, 3'd0, '0, '0, 1'b0);
      send(5'd31, 3'd0, '0, '0, 1'b0);
      send(5'd19, 3'd0, '0, '0, 1'b0);
   endtask

   // drive the machine into one fault, then a few items while halted
   task automatic fault_and_halt();
      logic [rsm_pkg::REG_W-1:0] r;
      r = $urandom;
      case ($urandom_range(1, 5))
         1: begin
            while (depth > 0) send(rsm_pkg::OP_POP, r, $urandom, $urandom, $urandom);
            send($urandom_range(1) ? rsm_pkg::OP_POP : rsm_pkg::OP_ADD, r, $urandom,
                 $urandom, $urandom);
         end
         2: begin
            while (depth < rsm_pkg::STACK_DEPTH)
               send(rsm_pkg::OP_PUSH, r, $urandom, $urandom, $urandom);
            send($urandom_range(1) ? rsm_pkg::OP_PUSH : rsm_pkg::OP_JSR, r, $urandom,
                 $urandom, 1'b0);
         end
         3: begin
            while (depth > 2) send(rsm_pkg::OP_POP, r, $urandom, $urandom, $urandom);
            send(rsm_pkg::OP_CONST, r, 32'h0, $urandom, $urandom);
            send(rsm_pkg::OP_PUSH, r, $urandom, $urandom, $urandom);
            send(rsm_pkg::OP_PUSH, r, $urandom, $urandom, $urandom);
            send($urandom_range(1) ? rsm_pkg::OP_DIV : rsm_pkg::OP_MOD, r, $urandom,
                 $urandom, $urandom);
         end
         4: send(rsm_pkg::OP_BRNZP, r, $urandom, $urandom, 1'b0);
         default: begin
            send(rsm_pkg::OP_CONST, r, $urandom_range(1) ? 32'hFFFF_FFFB : 32'd1500,
                 $urandom, $urandom);
            send(rsm_pkg::OP_JMPR, r, $urandom, $urandom, $urandom);
         end
      endcase
      repeat (6) send($urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   initial begin
      logic [rsm_pkg::LEN_W-1:0] lengths [4];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = '0;
      req_reg_index    = '0;
      req_immediate    = '0;
      req_target_pc    = '0;
      req_target_found = 1'b0;
      csr_write        = 1'b0;
      csr_wdata        = '0;
      rsp_stall        = 1'b0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      sent             = 0;
      received         = 0;
      cycles           = 0;
      depth            = 0;
      prog_span        = rsm_pkg::PROG_DEPTH;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed();
      lengths = '{11'd1, rsm_pkg::LEN_W'($urandom_range(2, 1023)), 11'd2047, 11'd1024};
      for (int ph = 0; ph < 4; ph++) begin
         set_length(lengths[ph]);
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
         endcase
         repeat (45) random_step();
      end
      fault_and_halt();

      req_valid <= 1'b0;
      @(posedge clock);
      while (received != sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
